// ===== rtl/core/leq_pkg.sv =====
// Shared types and constants of the Leq sound level integrator.
// Has no dependencies; every other file of the block refers to it.
package leq_pkg;

  // Input sample and period widths.
  localparam int SAMPLE_BITS = 24;
  localparam int PERIOD_BITS = 18;

  // Accumulator and squared-sample widths.
  localparam int SUM_W = 64;
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  // Fixed-point log2: integer part (bit index) and fraction.
  localparam int EXP_W         = $clog2(SUM_W);
  localparam int LOG_FRAC_BITS = 20;
  localparam int LOG_W         = EXP_W + LOG_FRAC_BITS;
  localparam int MANT_W        = 32;
  localparam int NORM_STEPS    = EXP_W;
  localparam int STEP_W        = $clog2(NORM_STEPS);
  localparam int ITER_W        = $clog2(LOG_FRAC_BITS);

  // Full-scale offset of the mean square, 2*(SAMPLE_BITS-1) in log2 Q.20.
  localparam int LOG_OFFSET = (2 * (SAMPLE_BITS - 1)) << LOG_FRAC_BITS;

  // Level scaling: 10*log10(2) in Q16, product rounded back by 2^28.
  localparam int DIFF_W          = LOG_W + 2;
  localparam int NEG_W           = LOG_W + 1;
  localparam int SCALE_W         = 18;
  localparam int TEN_LOG10_2_Q16 = 197283;
  localparam int PROD_W          = NEG_W + SCALE_W;
  localparam int ROUND_SHIFT     = 28;
  localparam int Q_W             = PROD_W - ROUND_SHIFT + 1;

  // Output level format, signed Q8.8.
  localparam int LEVEL_W   = 17;
  localparam int LEVEL_MIN = -36864;
  localparam int LEVEL_MAG = 36864;

  // Queue between the accumulator and the level unit (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration space.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam int PERIOD_RESET = 48000;

  // One finished period: its sum of squares and its sample count.
  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [PERIOD_BITS-1:0] cnt;
  } acc_entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic       valid;
    acc_entry_t entry;
  } q_push_t;

  // Read side of the queue: head entry and whether it holds one.
  typedef struct packed {
    logic       valid;
    acc_entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/core/leq_sample_if.sv =====
// Valid/ready channel that carries one audio sample per transaction.
// Depends on leq_pkg for the sample width.
interface leq_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [leq_pkg::SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== rtl/core/leq_level_if.sv =====
// Valid/ready channel that carries one level result per transaction.
// Depends on leq_pkg for the level width.
interface leq_level_if;
  logic                              valid;
  logic                              ready;
  logic signed [leq_pkg::LEVEL_W-1:0] level_db;
  logic                              silent_flag;

  modport source (output valid, output level_db, output silent_flag, input ready);
  modport sink   (input valid, input level_db, input silent_flag, output ready);
endinterface

// ===== rtl/core/leq_front.sv =====
// Front end: squares each sample, accumulates sum and count, and pushes a
// finished period into the queue. Depends on leq_pkg and leq_sample_if.
module leq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  leq_sample_if.sink                      in_if,
  input  logic [leq_pkg::PERIOD_BITS-1:0] period,
  input  logic                            q_full,
  output leq_pkg::q_push_t                q_push
);

  logic                            sq_vld_r;
  logic [leq_pkg::SQ_W-1:0]        sq_r;
  logic [leq_pkg::SUM_W-1:0]       sum_r;
  logic [leq_pkg::PERIOD_BITS-1:0] cnt_r;

  logic [leq_pkg::SAMPLE_BITS-1:0] raw;
  logic [leq_pkg::SAMPLE_BITS-1:0] mag;
  logic [leq_pkg::SUM_W-1:0]       sum_add;
  logic [leq_pkg::PERIOD_BITS-1:0] cnt_inc;
  logic                            emit;
  logic                            adv;

  always_comb begin
    raw     = in_if.sample_value;
    mag     = raw[leq_pkg::SAMPLE_BITS-1] ? ((~raw) + leq_pkg::SAMPLE_BITS'(1)) : raw;
    sum_add = sum_r + leq_pkg::SUM_W'(sq_r);
    cnt_inc = cnt_r + leq_pkg::PERIOD_BITS'(1);
    // A period ends when the count reaches the period or wraps to zero.
    emit    = (cnt_inc >= period) || (cnt_inc == '0);
    adv     = !emit || !q_full;
  end

  assign in_if.ready        = !sq_vld_r || adv;
  assign q_push.valid       = sq_vld_r && emit && !q_full;
  assign q_push.entry.sum   = sum_add;
  assign q_push.entry.cnt   = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (sq_vld_r && adv) begin
        if (emit) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_inc;
        end
      end
      if (in_if.ready) begin
        sq_vld_r <= in_if.valid;
        sq_r     <= mag * mag;
      end
    end
  end

endmodule

// ===== rtl/core/leq_fifo.sv =====
// Short queue of finished periods between the front and back ends.
// Depends on leq_pkg for the entry type and depth.
module leq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  leq_pkg::q_push_t q_push,
  input  logic             q_pop,
  output logic             q_full,
  output leq_pkg::q_head_t q_head
);

  leq_pkg::acc_entry_t           mem_r [leq_pkg::QUEUE_DEPTH];
  logic [leq_pkg::QUEUE_AW-1:0]  wr_ptr_r;
  logic [leq_pkg::QUEUE_AW-1:0]  rd_ptr_r;
  logic [leq_pkg::QUEUE_AW:0]    fill_r;
  logic                          do_push;
  logic                          do_pop;

  assign q_full       = (fill_r == (leq_pkg::QUEUE_AW + 1)'(leq_pkg::QUEUE_DEPTH));
  assign q_head.valid = (fill_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];
  assign do_push      = q_push.valid && !q_full;
  assign do_pop       = q_pop && q_head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + leq_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + leq_pkg::QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + (leq_pkg::QUEUE_AW + 1)'(1);
        2'b01:   fill_r <= fill_r - (leq_pkg::QUEUE_AW + 1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/leq_back.sv =====
// Back end: turns a finished period into a dB FS level through two
// iterative log2 evaluations and a scale. Depends on leq_pkg, leq_level_if.
module leq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  leq_pkg::q_head_t q_head,
  output logic             q_pop,
  leq_level_if.source      out_if
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_MUL,
    S_FIX,
    S_DIFF,
    S_SCALE,
    S_ROUND,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [leq_pkg::SUM_W-1:0]           x_r;
  logic [leq_pkg::EXP_W-1:0]           e_r;
  logic [leq_pkg::STEP_W-1:0]          step_r;
  logic [leq_pkg::MANT_W-1:0]          m_r;
  logic [2*leq_pkg::MANT_W-1:0]        p_r;
  logic [leq_pkg::LOG_FRAC_BITS-1:0]   frac_r;
  logic [leq_pkg::ITER_W-1:0]          it_r;
  logic                                which_r;
  logic [leq_pkg::PERIOD_BITS-1:0]     cnt_hold_r;
  logic [leq_pkg::LOG_W-1:0]           lsum_r;
  logic [leq_pkg::LOG_W-1:0]           lcnt_r;
  logic [leq_pkg::NEG_W-1:0]           neg_r;
  logic [leq_pkg::PROD_W-1:0]          prod_r;
  logic signed [leq_pkg::LEVEL_W-1:0]  res_level_r;
  logic                                res_silent_r;
  logic                                out_valid_r;
  logic signed [leq_pkg::LEVEL_W-1:0]  out_level_r;
  logic                                out_silent_r;

  logic [leq_pkg::EXP_W-1:0]           sh;
  logic                                hi_zero;
  logic [leq_pkg::SUM_W-1:0]           x_nx;
  logic [leq_pkg::EXP_W-1:0]           e_nx;
  logic [leq_pkg::MANT_W:0]            t;
  logic                                fbit;
  logic [leq_pkg::MANT_W-1:0]          m_nx;
  logic [leq_pkg::LOG_FRAC_BITS-1:0]   frac_nx;
  logic signed [leq_pkg::DIFF_W-1:0]   d;
  logic signed [leq_pkg::DIFF_W-1:0]   negd;
  logic [leq_pkg::PROD_W:0]            q_sum;
  logic [leq_pkg::Q_W-1:0]             q;
  logic                                out_free;

  always_comb begin
    // Normalization: one halving of the shift width per step.
    sh      = leq_pkg::EXP_W'(leq_pkg::SUM_W / 2) >> step_r;
    hi_zero = ((x_r & ~({leq_pkg::SUM_W{1'b1}} >> sh)) == '0);
    x_nx    = hi_zero ? (x_r << sh) : x_r;
    e_nx    = hi_zero ? (e_r - sh) : e_r;
    // One squaring step of the mantissa.
    t       = p_r[2*leq_pkg::MANT_W-1 : leq_pkg::MANT_W-1];
    fbit    = t[leq_pkg::MANT_W];
    m_nx    = fbit ? t[leq_pkg::MANT_W:1] : t[leq_pkg::MANT_W-1:0];
    frac_nx = {frac_r[leq_pkg::LOG_FRAC_BITS-2:0], fbit};
    // Log difference relative to full scale.
    d       = $signed({2'b00, lsum_r}) - $signed({2'b00, lcnt_r})
              - leq_pkg::DIFF_W'(leq_pkg::LOG_OFFSET);
    negd    = -d;
    q_sum   = {1'b0, prod_r} + (leq_pkg::PROD_W + 1)'(1 << (leq_pkg::ROUND_SHIFT - 1));
    q       = q_sum[leq_pkg::PROD_W : leq_pkg::ROUND_SHIFT];
    out_free = !out_valid_r || out_if.ready;
  end

  assign q_pop              = (state_r == S_IDLE) && q_head.valid;
  assign out_if.valid       = out_valid_r;
  assign out_if.level_db    = out_level_r;
  assign out_if.silent_flag = out_silent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE a departing result is replaced by the next one instead.
      if (out_valid_r && out_if.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_head.valid) begin
            if ((q_head.entry.sum == '0) || (q_head.entry.cnt == '0)) begin
              res_level_r  <= leq_pkg::LEVEL_W'(leq_pkg::LEVEL_MIN);
              res_silent_r <= (q_head.entry.sum == '0);
              state_r      <= S_DONE;
            end else begin
              x_r        <= q_head.entry.sum;
              e_r        <= leq_pkg::EXP_W'(leq_pkg::SUM_W - 1);
              step_r     <= '0;
              which_r    <= 1'b0;
              cnt_hold_r <= q_head.entry.cnt;
              state_r    <= S_NORM;
            end
          end
        end
        S_NORM: begin
          x_r    <= x_nx;
          e_r    <= e_nx;
          step_r <= step_r + leq_pkg::STEP_W'(1);
          if (step_r == leq_pkg::STEP_W'(leq_pkg::NORM_STEPS - 1)) begin
            m_r     <= x_nx[leq_pkg::SUM_W-1 -: leq_pkg::MANT_W];
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_r     <= m_r * m_r;
          state_r <= S_FIX;
        end
        S_FIX: begin
          m_r    <= m_nx;
          frac_r <= frac_nx;
          it_r   <= it_r + leq_pkg::ITER_W'(1);
          if (it_r == leq_pkg::ITER_W'(leq_pkg::LOG_FRAC_BITS - 1)) begin
            if (!which_r) begin
              lsum_r  <= {e_r, frac_nx};
              x_r     <= leq_pkg::SUM_W'(cnt_hold_r);
              e_r     <= leq_pkg::EXP_W'(leq_pkg::SUM_W - 1);
              step_r  <= '0;
              which_r <= 1'b1;
              state_r <= S_NORM;
            end else begin
              lcnt_r  <= {e_r, frac_nx};
              state_r <= S_DIFF;
            end
          end else begin
            state_r <= S_MUL;
          end
        end
        S_DIFF: begin
          // Levels above full scale clamp to 0 dB.
          neg_r   <= d[leq_pkg::DIFF_W-1] ? negd[leq_pkg::NEG_W-1:0] : '0;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          prod_r  <= neg_r * leq_pkg::SCALE_W'(leq_pkg::TEN_LOG10_2_Q16);
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (q > leq_pkg::Q_W'(leq_pkg::LEVEL_MAG)) begin
            res_level_r <= leq_pkg::LEVEL_W'(leq_pkg::LEVEL_MIN);
          end else begin
            res_level_r <= -leq_pkg::LEVEL_W'(q);
          end
          res_silent_r <= 1'b0;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_level_r  <= res_level_r;
            out_silent_r <= res_silent_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/leq_sound_level_integrator.sv =====
// Top level of the Leq sound level integrator: configuration registers and
// the front end, queue and back end. Depends on leq_pkg, both channel interfaces.

// The block takes one filtered Q1.23 audio sample per transaction and, after
// every period_samples samples, delivers one transaction with the equivalent
// level of that period in dB full scale (signed Q8.8, floor -144 dB) and a
// silent flag that marks a period whose samples were all zero. Samples are
// taken at one per clock cycle: the squaring multiplier and the 64-bit
// accumulator form a two-stage front end that waits on the level math only
// when a period ends while the queue is full.
// Each finished period is parked in a two-entry queue, and the back end turns
// it into a level through two log2 evaluations of 20 mantissa squarings each,
// each squaring a multiply state and a fix-up state on one shared 32x32
// multiplier, plus six normalization steps per log2, then scaling and hand-off;
// an all-zero period goes straight to hand-off. The input therefore runs at full
// rate as long as the back end keeps up with the periods, and otherwise
// stalls only while the queue is full. The period register sits at byte
// address 0 of the APB-style port; it may only be written while the block
// holds no unfinished sample.
module leq_sound_level_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  leq_sample_if.sink                    in_if,
  leq_level_if.source                   out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [leq_pkg::CFG_AW-1:0]    paddr,
  input  logic [leq_pkg::CFG_DW-1:0]    pwdata,
  output logic [leq_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  logic [leq_pkg::PERIOD_BITS-1:0] period_r;
  logic [0:0]                      reg_idx;
  logic                            cfg_wr;
  logic                            q_full;
  logic                            q_pop;
  leq_pkg::q_push_t                q_push;
  leq_pkg::q_head_t                q_head;

  // Registers are word-spaced; the byte offset bits are not decoded.
  assign reg_idx = paddr[leq_pkg::CFG_AW-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == leq_pkg::REG_PERIOD);
  assign prdata  = (reg_idx == leq_pkg::REG_PERIOD) ? leq_pkg::CFG_DW'(period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= leq_pkg::PERIOD_BITS'(leq_pkg::PERIOD_RESET);
    end else if (cfg_wr) begin
      period_r <= pwdata[leq_pkg::PERIOD_BITS-1:0];
    end
  end

  // The front end squares and accumulates; it holds its sample whenever a
  // period ends while the queue is full.
  leq_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .period (period_r),
    .q_full (q_full),
    .q_push (q_push)
  );

  leq_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  // The back end computes the level and holds it in its output register
  // until the result transaction completes.
  leq_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule

// ===== tb/tb_leq_sound_level_integrator.sv =====
// Self-checking testbench for the Leq sound level integrator.
// Depends on leq_pkg, leq_sample_if, leq_level_if and the leq_sound_level_integrator RTL.
module tb_leq_sound_level_integrator;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that decodes to nothing; writes there must leave the period alone.
  localparam int UNMAPPED_REG   = 1;
  localparam int LONGEST_PERIOD = (1 << leq_pkg::PERIOD_BITS) - 1;
  localparam int LONG_RUN_ITEMS = 24;
  // Settle time that covers the back end's work on a result and the front end too.
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 740;

  localparam logic signed [leq_pkg::SAMPLE_BITS-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [leq_pkg::SAMPLE_BITS-1:0] FULL_NEG = 24'sh800000;

  // One level result as the block should deliver it.
  typedef struct packed {
    logic signed [leq_pkg::LEVEL_W-1:0] level_db;
    logic                               silent_flag;
  } level_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // APB-style configuration port.
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [leq_pkg::CFG_AW-1:0]   paddr;
  logic [leq_pkg::CFG_DW-1:0]   pwdata;
  logic [leq_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;

  leq_sample_if sample_ch();
  leq_level_if  level_ch();

  // The result side is driven from one process only, through this variable.
  logic level_ready = 1'b0;
  assign level_ch.ready = level_ready;

  // Predicted state of the integrator: running energy, samples in the current
  // window and the programmed window length.
  logic [leq_pkg::SUM_W-1:0]       energy_acc;
  logic [leq_pkg::PERIOD_BITS-1:0] samples_in_window;
  logic [leq_pkg::PERIOD_BITS-1:0] window_len;

  // Levels still owed by the block, oldest first.
  level_result_t expected_levels[$];

  bit gaps_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;

  leq_sound_level_integrator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (sample_ch),
    .out_if  (level_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Counts every failure; only the first ten get a line of their own.
  function automatic void note_mismatch(string what, longint want, longint got);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Fixed-point log2 with 20 fractional bits. The integer part is the index of
  // the top set bit; the fraction comes from repeatedly squaring a Q1.31
  // mantissa, where each square that reaches 2.0 yields a one bit.
  function automatic logic [63:0] log2_q20(input logic [63:0] x);
    int                                msb;
    logic [63:0]                       m;
    logic [leq_pkg::LOG_FRAC_BITS-1:0] frac;
    msb  = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) msb = i;
    end
    m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    repeat (leq_pkg::LOG_FRAC_BITS) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return (64'(msb) << leq_pkg::LOG_FRAC_BITS) | 64'(frac);
  endfunction

  // Adds one accepted sample to the predicted window. Returns 1 and the
  // expected level when this sample closes the window.
  function automatic bit integrate_sample(
      input logic signed [leq_pkg::SAMPLE_BITS-1:0] value,
      output level_result_t res);
    logic [leq_pkg::SAMPLE_BITS-1:0] mag;
    longint                          diff;
    longint                          q;
    mag = value[leq_pkg::SAMPLE_BITS-1] ? (~value + 1'b1) : value;
    energy_acc        = energy_acc + 64'(mag) * 64'(mag);
    samples_in_window = samples_in_window + 1'b1;
    if (samples_in_window < window_len && samples_in_window != 0) return 1'b0;

    res.silent_flag = (energy_acc == 0);
    if (energy_acc == 0 || samples_in_window == 0) begin
      res.level_db = leq_pkg::LEVEL_W'(leq_pkg::LEVEL_MIN);
    end else begin
      // Mean square relative to full scale, in log2 Q.20, never above 0 dB.
      diff = longint'(log2_q20(energy_acc)) - longint'(log2_q20(64'(samples_in_window)))
           - longint'(leq_pkg::LOG_OFFSET);
      if (diff > 0) diff = 0;
      q = (-diff * leq_pkg::TEN_LOG10_2_Q16 + (longint'(1) << (leq_pkg::ROUND_SHIFT - 1)))
          >>> leq_pkg::ROUND_SHIFT;
      res.level_db = (q > leq_pkg::LEVEL_MAG) ? leq_pkg::LEVEL_W'(leq_pkg::LEVEL_MIN)
                                              : leq_pkg::LEVEL_W'(-q);
    end
    energy_acc        = '0;
    samples_in_window = '0;
    return 1'b1;
  endfunction

  // Mix of amplitudes: silence, full scale, tiny values, scaled and raw random.
  function automatic logic signed [leq_pkg::SAMPLE_BITS-1:0] pick_sample();
    logic signed [leq_pkg::SAMPLE_BITS-1:0] v;
    v = leq_pkg::SAMPLE_BITS'($urandom());
    case ($urandom_range(0, 9))
      0, 1: v = '0;
      2: v = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
      3, 4: v = leq_pkg::SAMPLE_BITS'($urandom_range(0, 32)) - leq_pkg::SAMPLE_BITS'(16);
      5, 6: v = v >>> $urandom_range(0, leq_pkg::SAMPLE_BITS - 1);
      default: ;
    endcase
    return v;
  endfunction

  // Offers one sample and waits for its transaction. Valid stays high on
  // return so that back-to-back samples stream at full rate; wait_idle or a
  // gap lowers it.
  task automatic send_sample(input logic signed [leq_pkg::SAMPLE_BITS-1:0] value);
    level_result_t res;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample_ch.valid        = 1'b1;
    sample_ch.sample_value = value;
    do @(posedge clk); while (!sample_ch.ready);
    if (integrate_sample(value, res)) expected_levels.push_back(res);
    samples_sent++;
    @(negedge clk);
  endtask

  // Stops the sample stream, waits for every owed level, then lets the
  // pipeline settle so the block is idle before any register write.
  task automatic wait_idle();
    sample_ch.valid = 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Reads the period register and compares it with the predicted value.
  task automatic check_period_register();
    logic [leq_pkg::CFG_DW-1:0] seen;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = leq_pkg::CFG_AW'(4 * leq_pkg::REG_PERIOD);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (seen !== leq_pkg::CFG_DW'(window_len)) begin
      note_mismatch("period readback", window_len, seen);
    end
  endtask

  // Setup and access phase of one write, then a readback of the period.
  task automatic cfg_write(input int index, input logic [leq_pkg::CFG_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = leq_pkg::CFG_AW'(4 * index);
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (index == leq_pkg::REG_PERIOD) window_len = data[leq_pkg::PERIOD_BITS-1:0];
    cfg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    check_period_register();
  endtask

  // Result side: ready drops for random stall bursts while gaps are enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      level_ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      level_ready <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      level_ready <= 1'b1;
    end
  end

  // Every delivered level is compared with the oldest prediction.
  always @(posedge clk) begin
    level_result_t want;
    if (rst_n && level_ch.valid && level_ch.ready) begin
      results_checked++;
      if (expected_levels.size() == 0) begin
        note_mismatch("level with none outstanding", 0, level_ch.level_db);
      end else begin
        want = expected_levels.pop_front();
        if (level_ch.level_db !== want.level_db) begin
          note_mismatch("level_db", want.level_db, level_ch.level_db);
        end
        if (level_ch.silent_flag !== want.silent_flag) begin
          note_mismatch("silent_flag", want.silent_flag, level_ch.silent_flag);
        end
      end
    end
  end

  // Ends a hung run: too many cycles without any transaction on any port.
  always @(posedge clk) begin
    if (!rst_n || psel || (sample_ch.valid && sample_ch.ready) ||
        (level_ch.valid && level_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // After reset the period must read back as its reset value.
  task automatic test_reset_state();
    check_period_register();
  endtask

  // Full-scale samples of both signs, and windows of zero and one sample
  // that produce a level on every transaction.
  task automatic test_signal_extremes();
    // Bits above the register width are set and must be dropped.
    cfg_write(leq_pkg::REG_PERIOD, 32'hFFFC_0004);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample('0);
    send_sample(-24'sd1);
    wait_idle();
    cfg_write(leq_pkg::REG_PERIOD, 32'd0);
    send_sample(FULL_NEG);
    send_sample('0);
    wait_idle();
    cfg_write(leq_pkg::REG_PERIOD, 32'd1);
    send_sample(FULL_POS);
    wait_idle();
  endtask

  // An all-zero window raises the flag; a window quieter than -144 dB only
  // saturates the level and leaves the flag clear.
  task automatic test_silence_and_floor();
    cfg_write(leq_pkg::REG_PERIOD, 32'd2);
    send_sample('0);
    send_sample('0);
    wait_idle();
    cfg_write(leq_pkg::REG_PERIOD, 32'd4);
    send_sample(24'sd1);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    wait_idle();
  endtask

  // A write to an undecoded address must not touch the period.
  task automatic test_unmapped_register();
    cfg_write(UNMAPPED_REG, 32'd3);
    send_sample('0);
    send_sample(24'sd5);
    send_sample('0);
    send_sample('0);
    wait_idle();
  endtask

  // Lowering the period below the samples already counted closes the window
  // on the very next sample, over all samples counted so far.
  task automatic test_period_lowered();
    cfg_write(leq_pkg::REG_PERIOD, 32'd64);
    repeat (6) send_sample(pick_sample());
    wait_idle();
    cfg_write(leq_pkg::REG_PERIOD, 32'd5);
    send_sample(pick_sample());
    wait_idle();
  endtask

  // The largest period: a short gapless stream stays inside the window and
  // yields nothing, then a period of one closes it over those samples.
  task automatic test_longest_period();
    gaps_on = 1'b0;
    cfg_write(leq_pkg::REG_PERIOD, leq_pkg::CFG_DW'(LONGEST_PERIOD));
    repeat (LONG_RUN_ITEMS) send_sample(pick_sample());
    wait_idle();
    cfg_write(leq_pkg::REG_PERIOD, 32'd1);
    send_sample(pick_sample());
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // Random phases: a new period each time, mostly short so that levels come
  // often. Partial windows carry over into the next phase, so periods also
  // get lowered under a running count. The last quarter runs without gaps.
  task automatic test_random_traffic();
    int                         sent_here;
    int                         burst;
    int                         span;
    bit                         quiet;
    logic [leq_pkg::CFG_DW-1:0] word;
    sent_here = 0;
    span      = 64;
    while (sent_here < RANDOM_ITEMS) begin
      word                             = $urandom();
      word[leq_pkg::PERIOD_BITS-1:0]   = leq_pkg::PERIOD_BITS'(span);
      cfg_write(leq_pkg::REG_PERIOD, word);
      if ($urandom_range(0, 7) == 0) cfg_write(UNMAPPED_REG, $urandom());
      gaps_on = (sent_here < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
      quiet   = ($urandom_range(0, 5) == 0);
      burst   = $urandom_range(10, 90);
      repeat (burst) begin
        if (quiet) send_sample('0);
        else send_sample(pick_sample());
      end
      sent_here += burst;
      wait_idle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: span = $urandom_range(0, 12);
        4, 5, 6, 7: span = $urandom_range(13, 40);
        8:          span = $urandom_range(64, 130);
        default:    span = $urandom_range(41, 63);
      endcase
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    energy_acc             = '0;
    samples_in_window      = '0;
    window_len             = leq_pkg::PERIOD_BITS'(leq_pkg::PERIOD_RESET);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_signal_extremes();
    test_silence_and_floor();
    test_unmapped_register();
    test_period_lowered();
    test_longest_period();
    test_random_traffic();

    $display("Run covered %0d samples, %0d level results and %0d register writes.",
             samples_sent, results_checked, cfg_writes);
    $display("Periods 0 to %0d, silent windows, the -144 dB floor, %0d mismatches.",
             LONGEST_PERIOD, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== leq_sound_level_integrator.f =====
rtl/core/leq_pkg.sv
rtl/core/leq_sample_if.sv
rtl/core/leq_level_if.sv
rtl/core/leq_front.sv
rtl/core/leq_fifo.sv
rtl/core/leq_back.sv
rtl/core/leq_sound_level_integrator.sv
tb/tb_leq_sound_level_integrator.sv
